// ----- rtl/core/ttm_pkg.sv -----
// Shared types, constants and helpers for the texture transform matrix block.
`timescale 1ns / 1ps

package ttm_pkg;

  // CORDIC length and start value (gain-compensated unit vector, 30 fractional bits).
  localparam int CORDIC_STEPS = 28;
  localparam logic signed [32:0] CORDIC_GAIN_INIT = 33'sh026DD3B6A;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [0:31] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [31:0] center_u;
    logic signed [31:0] center_v;
    logic signed [31:0] offset_u;
    logic signed [31:0] offset_v;
    logic        [15:0] turn_angle;
    logic signed [31:0] stretch_u;
    logic signed [31:0] stretch_v;
  } ttm_in_t;

  typedef struct packed {
    logic signed [31:0] coef_uu;
    logic signed [31:0] coef_uv;
    logic signed [31:0] coef_vu;
    logic signed [31:0] coef_vv;
    logic signed [31:0] shift_u;
    logic signed [31:0] shift_v;
  } ttm_out_t;

  // Clamps a wide signed value to the int32 range.
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] r;
    if (v > 80'sh0_0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -80'sh0_0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ttm_in_if.sv -----
// Request channel carrying one set of transform parameters.
`timescale 1ns / 1ps

interface ttm_in_if import ttm_pkg::*; ();
  logic    valid;
  logic    ready;
  ttm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ttm_out_if.sv -----
// Result channel carrying one finished matrix.
`timescale 1ns / 1ps

interface ttm_out_if import ttm_pkg::*; ();
  logic     valid;
  logic     ready;
  ttm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/texture_transform_matrix.sv -----
// Pipeline: 1 input register, 28 CORDIC stages and 5 arithmetic stages (A to E) lie between
// an accepted request and its result. Throughput: one request per cycle while the output is
// not held; the CORDIC is fully unrolled into one pipeline stage per iteration; B and D multiply.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears only the stage valid bits.
`timescale 1ns / 1ps

module texture_transform_matrix
  import ttm_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ttm_in_if.sink    in_ch,
  ttm_out_if.source out_ch
);

  localparam int STEPS = CORDIC_STEPS;
  localparam int DROP  = 30 - FRAC_BITS;
  localparam int CW    = FRAC_BITS + 2;        // sine / cosine width
  localparam int PW    = CW + 34;              // co * w product width
  localparam int SW    = PW + 1;               // inner sum width
  localparam int IW    = SW - FRAC_BITS;       // rounded inner sum width
  localparam int LOW   = 18;                   // low part width of the split multiply
  localparam int HW    = IW - LOW;             // high part width
  localparam int LW    = 32 + CW;              // linear product width
  localparam int TW    = 32 + IW + 2;          // recombined product width

  localparam logic signed [33:0] HALF_D   = 34'sd1 <<< (DROP - 1);
  localparam logic signed [79:0] HALF_F   = 80'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [33:0] ONE      = 34'sd1 <<< FRAC_BITS;

  logic en;
  logic vE_r;

  assign en          = !vE_r || out_ch.ready;
  assign in_ch.ready = en;

  // CORDIC pipeline: index 0 is the input register, index i holds the result of i steps.
  logic                     cv_r   [0:STEPS];
  logic signed [32:0]       cx_r   [0:STEPS];
  logic signed [32:0]       cy_r   [0:STEPS];
  logic signed [32:0]       cz_r   [0:STEPS];
  logic        [1:0]        quad_r [0:STEPS];
  ttm_in_t                  carry_r[0:STEPS];

  logic [31:0] phase;
  assign phase = {16'b0, in_ch.data.turn_angle} << (32 - ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]    <= CORDIC_GAIN_INIT;
      cy_r[0]    <= '0;
      cz_r[0]    <= {3'b000, phase[29:0]};
      quad_r[0]  <= phase[31:30];
      carry_r[0] <= in_ch.data;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    logic signed [32:0] atan_s;
    assign atan_s = {1'b0, ATAN_TURN[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][32]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - atan_s;
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + atan_s;
        end
        quad_r[i+1]  <= quad_r[i];
        carry_r[i+1] <= carry_r[i];
      end
    end
  end

  // Stage A: quadrant fold, rounding to FRAC_BITS, offset vector.
  logic signed [32:0] fc, fs;
  logic signed [33:0] rc, rs;

  always_comb begin
    unique case (quad_r[STEPS])
      2'd0: begin fc = cx_r[STEPS];  fs = cy_r[STEPS];  end
      2'd1: begin fc = -cy_r[STEPS]; fs = cx_r[STEPS];  end
      2'd2: begin fc = -cx_r[STEPS]; fs = -cy_r[STEPS]; end
      default: begin fc = cy_r[STEPS]; fs = -cx_r[STEPS]; end
    endcase
    rc = (34'(fc) + HALF_D) >>> DROP;
    rs = (34'(fs) + HALF_D) >>> DROP;
  end

  logic                 vA_r;
  logic signed [CW-1:0] coA_r, siA_r;
  logic signed [33:0]   wuA_r, wvA_r;
  ttm_in_t              pA_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vA_r <= 1'b0;
    end else if (en) begin
      vA_r <= cv_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coA_r <= CW'(rc);
      siA_r <= CW'(rs);
      wuA_r <= 34'(carry_r[STEPS].center_u) + 34'(carry_r[STEPS].offset_u);
      wvA_r <= -34'(carry_r[STEPS].center_v) - ONE - 34'(carry_r[STEPS].offset_v);
      pA_r  <= carry_r[STEPS];
    end
  end

  // Stage B: all products of sine and cosine.
  logic                 vB_r;
  logic signed [PW-1:0] p1B_r, p2B_r, p3B_r, p4B_r;
  logic signed [LW-1:0] luuB_r, luvB_r, lvuB_r, lvvB_r;
  ttm_in_t              pB_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vB_r <= 1'b0;
    end else if (en) begin
      vB_r <= vA_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1B_r  <= PW'(coA_r * wuA_r);
      p2B_r  <= PW'(siA_r * wvA_r);
      p3B_r  <= PW'(coA_r * wvA_r);
      p4B_r  <= PW'(siA_r * wuA_r);
      luuB_r <= LW'(pA_r.stretch_u * coA_r);
      luvB_r <= LW'(pA_r.stretch_u * siA_r);
      lvuB_r <= LW'(pA_r.stretch_v * siA_r);
      lvvB_r <= LW'(pA_r.stretch_v * coA_r);
      pB_r   <= pA_r;
    end
  end

  // Stage C: round inner sums and linear entries.
  logic signed [79:0] suC, svC;
  assign suC = (80'(p1B_r) + 80'(p2B_r) + HALF_F) >>> FRAC_BITS;
  assign svC = (80'(p3B_r) - 80'(p4B_r) + HALF_F) >>> FRAC_BITS;

  logic                 vC_r;
  logic signed [IW-1:0] iuC_r, ivC_r;
  logic signed [31:0]   uuC_r, uvC_r, vuC_r, vvC_r;
  ttm_in_t              pC_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vC_r <= 1'b0;
    end else if (en) begin
      vC_r <= vB_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iuC_r <= IW'(suC);
      ivC_r <= IW'(svC);
      uuC_r <= sat32((80'(luuB_r) + HALF_F) >>> FRAC_BITS);
      uvC_r <= sat32((80'(luvB_r) + HALF_F) >>> FRAC_BITS);
      vuC_r <= sat32(-((80'(lvuB_r) + HALF_F) >>> FRAC_BITS));
      vvC_r <= sat32((80'(lvvB_r) + HALF_F) >>> FRAC_BITS);
      pC_r  <= pB_r;
    end
  end

  // Stage D: scale times inner sum, split into high and low partial products.
  logic signed [LOW:0] iulo, ivlo;
  assign iulo = {1'b0, iuC_r[LOW-1:0]};
  assign ivlo = {1'b0, ivC_r[LOW-1:0]};

  logic                    vD_r;
  logic signed [31+HW:0]   uhD_r, vhD_r;
  logic signed [32+LOW:0]  ulD_r, vlD_r;
  logic signed [31:0]      uuD_r, uvD_r, vuD_r, vvD_r, cuD_r, cvD_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vD_r <= 1'b0;
    end else if (en) begin
      vD_r <= vC_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      uhD_r <= (32 + HW)'(pC_r.stretch_u * $signed(iuC_r[IW-1:LOW]));
      vhD_r <= (32 + HW)'(pC_r.stretch_v * $signed(ivC_r[IW-1:LOW]));
      ulD_r <= (33 + LOW)'(pC_r.stretch_u * iulo);
      vlD_r <= (33 + LOW)'(pC_r.stretch_v * ivlo);
      uuD_r <= uuC_r;
      uvD_r <= uvC_r;
      vuD_r <= vuC_r;
      vvD_r <= vvC_r;
      cuD_r <= pC_r.center_u;
      cvD_r <= pC_r.center_v;
    end
  end

  // Stage E: recombine, round, apply the centre terms and saturate into the output register.
  logic signed [79:0] tu, tv, ru, rv;
  always_comb begin
    tu = (80'(uhD_r) <<< LOW) + 80'(ulD_r);
    tv = (80'(vhD_r) <<< LOW) + 80'(vlD_r);
    ru = ((tu + HALF_F) >>> FRAC_BITS) - 80'(cuD_r);
    rv = ((tv + HALF_F) >>> FRAC_BITS) + 80'(cvD_r) + 80'(ONE);
  end

  ttm_out_t outE_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vE_r <= 1'b0;
    end else if (en) begin
      vE_r <= vD_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outE_r.coef_uu <= uuD_r;
      outE_r.coef_uv <= uvD_r;
      outE_r.coef_vu <= vuD_r;
      outE_r.coef_vv <= vvD_r;
      outE_r.shift_u <= sat32(ru);
      outE_r.shift_v <= sat32(rv);
    end
  end

  assign out_ch.valid = vE_r;
  assign out_ch.data  = outE_r;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the texture transform matrix block.
`timescale 1ns / 1ps

module tb;
  import ttm_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int     FRAC       = 16;
  localparam wide_t  ONE        = wide_t'(1) <<< FRAC;
  localparam int     N_RANDOM   = 1750;
  localparam int     STALL_MAX  = 14;
  localparam int     IDLE_LIMIT = 4000;
  localparam int     DRAIN_WAIT = 60;

  // Fixed-point matrix predictor and queue of matrices still owed by the block.
  class matrix_scoreboard;
    ttm_out_t owed[$];

    static function wide_t round_q(wide_t v);
      return (v + (wide_t'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    static function logic signed [31:0] clamp32(wide_t v);
      if (v > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    static function ttm_out_t predict(ttm_in_t r);
      ttm_out_t m;
      logic [31:0] phase;
      longint x, y, z, nx, cx, sx;
      wide_t c, s, cu, cv, pu, pv, su, sv, wu, wv, iu, iv;
      phase = {r.turn_angle, 16'h0000};
      z = longint'({34'b0, phase[29:0]});
      x = longint'(CORDIC_GAIN_INIT);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - longint'({32'b0, ATAN_TURN[i]});
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + longint'({32'b0, ATAN_TURN[i]});
        end
        x = nx;
      end
      case (phase[31:30])
        2'd0: begin cx = x;  sx = y;  end
        2'd1: begin cx = -y; sx = x;  end
        2'd2: begin cx = -x; sx = -y; end
        default: begin cx = y; sx = -x; end
      endcase
      // Drop from 30 to FRAC fractional bits, rounding half up.
      c = wide_t'((cx + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));
      s = wide_t'((sx + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));
      cu = r.center_u; cv = r.center_v;
      pu = r.offset_u; pv = r.offset_v;
      su = r.stretch_u; sv = r.stretch_v;
      wu = cu + pu;
      wv = -cv - ONE - pv;
      iu = round_q(c * wu + s * wv);
      iv = round_q(c * wv - s * wu);
      m.coef_uu = clamp32(round_q(su * c));
      m.coef_uv = clamp32(round_q(su * s));
      m.coef_vu = clamp32(-round_q(sv * s));
      m.coef_vv = clamp32(round_q(sv * c));
      m.shift_u = clamp32(round_q(su * iu) - cu);
      m.shift_v = clamp32(round_q(sv * iv) + cv + ONE);
      return m;
    endfunction

    function void note_request(ttm_in_t r);
      owed = {owed, predict(r)};
    endfunction

    // Returns one message per wrong field; an empty queue means a match.
    function void check_matrix(ttm_out_t got, ref string faults[$]);
      ttm_out_t exp_m;
      faults = {};
      if (owed.size() == 0) begin
        faults = {faults, "result arrived with no request outstanding"};
        return;
      end
      exp_m = owed.pop_front();
      if (got.coef_uu !== exp_m.coef_uu)
        faults = {faults, $sformatf("coef_uu %h, want %h", got.coef_uu, exp_m.coef_uu)};
      if (got.coef_uv !== exp_m.coef_uv)
        faults = {faults, $sformatf("coef_uv %h, want %h", got.coef_uv, exp_m.coef_uv)};
      if (got.coef_vu !== exp_m.coef_vu)
        faults = {faults, $sformatf("coef_vu %h, want %h", got.coef_vu, exp_m.coef_vu)};
      if (got.coef_vv !== exp_m.coef_vv)
        faults = {faults, $sformatf("coef_vv %h, want %h", got.coef_vv, exp_m.coef_vv)};
      if (got.shift_u !== exp_m.shift_u)
        faults = {faults, $sformatf("shift_u %h, want %h", got.shift_u, exp_m.shift_u)};
      if (got.shift_v !== exp_m.shift_v)
        faults = {faults, $sformatf("shift_v %h, want %h", got.shift_v, exp_m.shift_v)};
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ttm_in_if  in_ch ();
  ttm_out_if out_ch ();

  matrix_scoreboard sb = new();
  int errors = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  bit sink_eager = 1'b0;
  int sink_hold = 0;

  texture_transform_matrix u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report(string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
    errors++;
  endtask

  // Requests and results are sampled before this edge's updates take effect.
  always @(posedge clk) begin
    string faults[$];
    if (rst_n && in_ch.valid && in_ch.ready) sb.note_request(in_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_matrix(out_ch.data, faults);
      foreach (faults[k]) report(faults[k]);
      results_seen++;
    end
  end

  // Result side back-pressure: a fresh wait is drawn for each result, with calm spells.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (results_seen % 150 == 0) sink_eager = ($urandom_range(0, 2) == 0);
        sink_hold = sink_eager ? 0 : $urandom_range(0, STALL_MAX);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("texture_transform_matrix verification failed");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Sends one request after a gap; valid stays high across back-to-back requests.
  task automatic send_request(ttm_in_t r, int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] pick_q(bit is_scale);
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 8)) - 4) <<< FRAC;
      default:
        if (is_scale) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        else return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic ttm_in_t make_request(logic [31:0] cu, logic [31:0] cv,
                                           logic [31:0] pu, logic [31:0] pv,
                                           logic [15:0] ang, logic [31:0] su,
                                           logic [31:0] sv);
    ttm_in_t r;
    r.center_u = cu; r.center_v = cv;
    r.offset_u = pu; r.offset_v = pv;
    r.turn_angle = ang;
    r.stretch_u = su; r.stretch_v = sv;
    return r;
  endfunction

  initial begin
    ttm_in_t directed[$];
    logic [15:0] quarter_angles[6];
    bit src_eager;
    int gap;
    quarter_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'hFFFF};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Quadrant boundaries and the angle wrap, unit and double scale, moderate centre.
    foreach (quarter_angles[k])
      directed = {directed, make_request(32'h0001_8000, 32'hFFFF_4000, 32'h0000_2000,
                                         32'h0003_0000, quarter_angles[k], 32'h0001_0000,
                                         32'h0002_0000)};
    directed = {directed, make_request('0, '0, '0, '0, '0, '0, '0)};
    directed = {directed, make_request('1, '1, '1, '1, 16'hFFFF, '1, '1)};
    // Zero and negative scales go through the ordinary formulas.
    directed = {directed, make_request(32'h0001_0000, 32'h0001_0000, 0, 0, 16'h1234,
                                       32'h0000_0000, 32'hFFFF_0000)};
    directed = {directed, make_request(32'hFFFE_0000, 32'h0000_8000, 32'h0005_0000,
                                       32'hFFFB_0000, 16'h9ABC, 32'hFFFD_0000,
                                       32'h0000_0000)};
    // Extreme and alternating-bit values, which can drive outputs into saturation one way or the other.
    directed = {directed, make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF, 16'h2000, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF)};
    directed = {directed, make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                       32'h8000_0000, 16'hA000, 32'h8000_0000,
                                       32'h8000_0000)};
    directed = {directed, make_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                       32'h7FFF_FFFF, 16'h6000, 32'h8000_0000,
                                       32'h7FFF_FFFF)};
    directed = {directed, make_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                       32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAA,
                                       32'h5555_5555)};
    directed = {directed, make_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                       32'h5555_5555, 16'hAAAA, 32'h5555_5555,
                                       32'hAAAA_AAAA)};
    foreach (directed[k]) send_request(directed[k], k % 3);

    src_eager = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 120 == 0) src_eager = ($urandom_range(0, 2) == 0);
      gap = src_eager ? 0 : $urandom_range(0, STALL_MAX);
      send_request(make_request(pick_q(0), pick_q(0), pick_q(0), pick_q(0),
                                16'($urandom()), pick_q(1), pick_q(1)), gap);
    end
    in_ch.valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("texture_transform_matrix verification clean");
    end else begin
      $display("texture_transform_matrix verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ttm_pkg.sv
rtl/core/ttm_in_if.sv
rtl/core/ttm_out_if.sv
rtl/core/texture_transform_matrix.sv
bench/tb.sv
